// ----- rtl/fmfw_pkg.sv -----
// Package for the packed monochrome frame store writer.
// Shared constants, operation codes and status structs. No dependencies.
package fmfw_pkg;

    // Default panel geometry (long side, short side) in pixels.
    localparam int PANEL_LONG_DEF  = 400;
    localparam int PANEL_SHORT_DEF = 300;

    // Command queue depth between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Command bits that do not depend on the store size:
    // kind(2) + data(8) + bit number(3) + white(1) + oob(1) + read address(14).
    localparam int CMD_FIXED_W = 29;

    // Store contents after reset.
    localparam logic [7:0] STORE_RESET_VALUE = 8'hFF;

    // Configuration register indexes.
    localparam logic REG_LANDSCAPE = 1'b0;
    localparam logic REG_POLARITY  = 1'b1;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_BLIT = 2'd1,
        OP_FILL = 2'd2,
        OP_READ = 2'd3
    } t_op;

    // Command kinds carried through the queue.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd_kind;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

// ----- rtl/packed_mono_framebuffer_writer.sv -----
// Packed one-bit-per-pixel frame store writer, top level.
// Depends on fmfw_pkg, fmfw_front, fmfw_queue and fmfw_back.
//
// Keeps a (PANEL_LONG*PANEL_SHORT/8)-byte frame store, one pixel per bit, each
// byte a 4x2 tile in portrait or a 2x4 tile with rows inverted in landscape.
// Set and blit requests each do a read-modify-write of one byte; they are
// taken at one per clock while the queue has room and retire at one per
// clock unless a fill or a waiting read result holds the back part, with
// back-to-back hits on the same byte covered by a forwarding path around the
// memory's registered read. A read passes the command queue, the memory's
// read register and the result register before o_out_valid rises. Off-panel
// pixels are dropped at the front and cost nothing in the back. A fill walks
// the store one byte per clock and holds the back part for all STORE_LEN
// bytes (15000 at 400x300); the four-entry queue keeps taking requests until
// it is full. After reset the same sweep writes 0xFF to every byte and no
// request is taken (o_in_ready stays low); register writes are taken at any
// time. One write port sets the sweep's pace. Registers: landscape_mode at
// byte address 0, source_black_is_zero at 4; write them only while idle.
module packed_mono_framebuffer_writer #(
    parameter int PANEL_LONG  = fmfw_pkg::PANEL_LONG_DEF,
    parameter int PANEL_SHORT = fmfw_pkg::PANEL_SHORT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [8:0]  i_pixel_x,
    input  logic [8:0]  i_pixel_y,
    input  logic [7:0]  i_data_value,
    input  logic [13:0] i_read_address,

    // read result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_byte_address,
    output logic [7:0]  o_byte_value,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW    = $clog2(PANEL_LONG * PANEL_SHORT / 8);
    localparam int CMD_W = fmfw_pkg::CMD_FIXED_W + AW;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic r_landscape;
    logic r_polarity;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_landscape <= 1'b1;
            r_polarity  <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[2])
                fmfw_pkg::REG_LANDSCAPE: r_landscape <= pwdata[0];
                fmfw_pkg::REG_POLARITY:  r_polarity  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fmfw_pkg::REG_LANDSCAPE: prdata = {31'd0, r_landscape};
            fmfw_pkg::REG_POLARITY:  prdata = {31'd0, r_polarity};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: coordinate mapping and classification
    // ---------------------------------------------------------------
    fmfw_pkg::t_q_status    q_status;
    fmfw_pkg::t_back_status back_status;
    logic                   q_push, q_pop;
    logic [CMD_W-1:0]       front_cmd, q_data;

    fmfw_front #(
        .PANEL_LONG  (PANEL_LONG),
        .PANEL_SHORT (PANEL_SHORT)
    ) u_front (
        .i_valid        (i_in_valid),
        .i_operation    (i_operation),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_data_value   (i_data_value),
        .i_read_address (i_read_address),
        .i_landscape    (r_landscape),
        .i_polarity     (r_polarity),
        .i_q_status     (q_status),
        .i_back_status  (back_status),
        .o_ready        (o_in_ready),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    // ---------------------------------------------------------------
    // Command queue: lets the front keep taking requests during a fill
    // or while a read result waits on the output.
    // ---------------------------------------------------------------
    fmfw_queue #(
        .WIDTH (CMD_W),
        .DEPTH (fmfw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (front_cmd),
        .i_pop    (q_pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    // ---------------------------------------------------------------
    // Back: frame memory, RMW pipe, fill/clear sweep, result register
    // ---------------------------------------------------------------
    fmfw_back #(
        .PANEL_LONG  (PANEL_LONG),
        .PANEL_SHORT (PANEL_SHORT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_q_data       (q_data),
        .o_pop          (q_pop),
        .o_status       (back_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_address (o_byte_address),
        .o_byte_value   (o_byte_value)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // reset always starts the clearing sweep
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> back_status.clearing)
        else $error("clearing sweep not started after reset");

    // no request may be taken while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.clearing |-> !o_in_ready)
        else $error("request ready during clearing sweep");

    // the front never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("push into full command queue");

    // the back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty command queue");

endmodule

// ----- rtl/fmfw_front.sv -----
// Front part: classifies requests and maps pixel coordinates to a byte and bit.
// Depends on fmfw_pkg.
module fmfw_front #(
    parameter int PANEL_LONG  = fmfw_pkg::PANEL_LONG_DEF,
    parameter int PANEL_SHORT = fmfw_pkg::PANEL_SHORT_DEF
) (
    input  logic                                   i_valid,
    input  logic [1:0]                             i_operation,
    input  logic [8:0]                             i_pixel_x,
    input  logic [8:0]                             i_pixel_y,
    input  logic [7:0]                             i_data_value,
    input  logic [13:0]                            i_read_address,
    input  logic                                   i_landscape,
    input  logic                                   i_polarity,
    input  fmfw_pkg::t_q_status                    i_q_status,
    input  fmfw_pkg::t_back_status                 i_back_status,
    output logic                                   o_ready,
    output logic                                   o_push,
    output logic [fmfw_pkg::CMD_FIXED_W
                  + $clog2(PANEL_LONG * PANEL_SHORT / 8) - 1:0] o_cmd
);

    localparam int STORE_LEN = PANEL_LONG * PANEL_SHORT / 8;
    localparam int AW        = $clog2(STORE_LEN);
    localparam int MAX_P     = (PANEL_LONG > PANEL_SHORT) ? PANEL_LONG : PANEL_SHORT;
    localparam int CW        = ($clog2(MAX_P + 1) > 9) ? $clog2(MAX_P + 1) : 9;
    localparam int KQ        = PANEL_SHORT / 4;
    localparam int IW        = 9 + $clog2(KQ + 1);
    localparam int RW        = ((AW > 14) ? AW : 14) + 1;

    localparam logic [CW-1:0] LONG_C   = CW'(PANEL_LONG);
    localparam logic [CW-1:0] SHORT_C  = CW'(PANEL_SHORT);
    localparam logic [IW-1:0] K_C      = IW'(KQ);
    localparam logic [IW:0]   STORE_IC = (IW + 1)'(STORE_LEN);
    localparam logic [RW-1:0] STORE_RC = RW'(STORE_LEN);

    typedef struct packed {
        fmfw_pkg::t_cmd_kind kind;
        logic [AW-1:0]       addr;
        logic [7:0]          data;
        logic [2:0]          bitn;
        logic                white;
        logic                oob;
        logic [13:0]         raddr;
    } t_cmd;

    logic [CW-1:0] x_e, y_e, iy;
    logic [7:0]    mul_a;
    logic [IW-1:0] add_b, idx;
    logic [2:0]    bitn;
    logic          in_panel, idx_ok, keep, oob;
    logic [RW-1:0] ra;
    t_cmd          cmd;

    always_comb begin
        x_e = CW'(i_pixel_x);
        y_e = CW'(i_pixel_y);
        // inverted row for landscape; only meaningful when y is on the panel
        iy  = SHORT_C - CW'(1) - y_e;

        if (i_landscape) begin
            in_panel = (x_e < LONG_C) && (y_e < SHORT_C);
            mul_a    = i_pixel_x[8:1];
            add_b    = IW'(iy[CW-1:2]);
            bitn     = ~{iy[1:0], i_pixel_x[0]};
        end else begin
            in_panel = (x_e < SHORT_C) && (y_e < LONG_C);
            mul_a    = i_pixel_y[8:1];
            add_b    = IW'(i_pixel_x[8:2]);
            bitn     = ~{i_pixel_x[1:0], i_pixel_y[0]};
        end

        // tiles per row is short/4 in both layouts: one constant multiplier
        idx    = IW'(mul_a) * K_C + add_b;
        idx_ok = {1'b0, idx} < STORE_IC;

        ra  = RW'(i_read_address);
        oob = ra >= STORE_RC;

        cmd.kind  = fmfw_pkg::CMD_WRITE;
        cmd.addr  = AW'(idx);
        cmd.data  = i_data_value;
        cmd.bitn  = bitn;
        cmd.white = 1'b0;
        cmd.oob   = 1'b0;
        cmd.raddr = i_read_address;
        keep      = 1'b0;

        case (fmfw_pkg::t_op'(i_operation))
            fmfw_pkg::OP_SET: begin
                cmd.white = |i_data_value;
                keep      = in_panel && idx_ok;
            end
            fmfw_pkg::OP_BLIT: begin
                cmd.white = i_polarity ? i_data_value[0] : ~i_data_value[0];
                keep      = in_panel && idx_ok;
            end
            fmfw_pkg::OP_FILL: begin
                cmd.kind = fmfw_pkg::CMD_FILL;
                keep     = 1'b1;
            end
            fmfw_pkg::OP_READ: begin
                cmd.kind = fmfw_pkg::CMD_READ;
                cmd.oob  = oob;
                cmd.addr = oob ? '0 : AW'(i_read_address);
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_ready = !i_q_status.full && !i_back_status.clearing;
    assign o_push  = i_valid && o_ready && keep;
    assign o_cmd   = cmd;

endmodule

// ----- rtl/fmfw_queue.sv -----
// Short command queue between the front and back parts.
// Depends on fmfw_pkg for the status struct.
module fmfw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fmfw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output fmfw_pkg::t_q_status o_status
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != CNTW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == CNTW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- rtl/fmfw_back.sv -----
// Back part: frame store memory, read-modify-write pipe, fill sweep, read results.
// Depends on fmfw_pkg.
module fmfw_back #(
    parameter int PANEL_LONG  = fmfw_pkg::PANEL_LONG_DEF,
    parameter int PANEL_SHORT = fmfw_pkg::PANEL_SHORT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fmfw_pkg::t_q_status           i_q_status,
    input  logic [fmfw_pkg::CMD_FIXED_W
                  + $clog2(PANEL_LONG * PANEL_SHORT / 8) - 1:0] i_q_data,
    output logic                          o_pop,
    output fmfw_pkg::t_back_status        o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [13:0]                   o_byte_address,
    output logic [7:0]                    o_byte_value
);

    localparam int STORE_LEN = PANEL_LONG * PANEL_SHORT / 8;
    localparam int AW        = $clog2(STORE_LEN);
    localparam logic [AW-1:0] LAST_POS = AW'(STORE_LEN - 1);

    typedef struct packed {
        fmfw_pkg::t_cmd_kind kind;
        logic [AW-1:0]       addr;
        logic [7:0]          data;
        logic [2:0]          bitn;
        logic                white;
        logic                oob;
        logic [13:0]         raddr;
    } t_cmd;

    logic [7:0] mem_store [STORE_LEN];

    fmfw_pkg::t_back_state r_state, n_state;
    logic [AW-1:0] r_sweep_pos, n_sweep_pos;
    logic [7:0]    r_sweep_val, n_sweep_val;
    logic          r_clearing, n_clearing;
    t_cmd          r_s2, n_s2;
    logic          r_s2_valid, n_s2_valid;
    logic          r_fwd_valid, n_fwd_valid;
    logic [AW-1:0] r_fwd_addr, n_fwd_addr;
    logic [7:0]    r_fwd_data, n_fwd_data;
    logic          r_out_valid, n_out_valid;
    logic [13:0]   r_out_addr, n_out_addr;
    logic [7:0]    r_out_val, n_out_val;
    logic [7:0]    r_rdata;

    t_cmd          q_cmd;
    logic          fwd_hit, s2_write, s2_read, adv, pop, enter;
    logic [7:0]    cur, mask, merged;
    logic          we, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data;

    always_comb begin
        q_cmd    = t_cmd'(i_q_data);
        // a write landing on the edge this read was issued is not in r_rdata yet
        fwd_hit  = r_fwd_valid && (r_fwd_addr == r_s2.addr);
        cur      = fwd_hit ? r_fwd_data : r_rdata;
        mask     = 8'b1 << r_s2.bitn;
        merged   = r_s2.white ? (cur | mask) : (cur & ~mask);
        s2_write = r_s2_valid && (r_s2.kind == fmfw_pkg::CMD_WRITE);
        s2_read  = r_s2_valid && (r_s2.kind == fmfw_pkg::CMD_READ);
        adv      = !s2_read || !r_out_valid || i_out_ready;
        pop      = (r_state == fmfw_pkg::ST_RUN) && adv && !i_q_status.empty;
        enter    = pop && (q_cmd.kind != fmfw_pkg::CMD_FILL);

        n_state     = r_state;
        n_sweep_pos = r_sweep_pos;
        n_sweep_val = r_sweep_val;
        n_clearing  = r_clearing;
        n_s2        = r_s2;
        n_s2_valid  = r_s2_valid;
        n_fwd_valid = r_fwd_valid;
        n_fwd_addr  = r_fwd_addr;
        n_fwd_data  = r_fwd_data;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_val   = r_out_val;

        we      = 1'b0;
        wr_addr = r_s2.addr;
        wr_data = merged;
        rd_en   = enter;
        rd_addr = q_cmd.addr;

        case (r_state)
            fmfw_pkg::ST_SWEEP: begin
                we      = 1'b1;
                wr_addr = r_sweep_pos;
                wr_data = r_sweep_val;
                if (r_sweep_pos == LAST_POS) begin
                    n_state     = fmfw_pkg::ST_RUN;
                    n_sweep_pos = '0;
                    n_clearing  = 1'b0;
                end else begin
                    n_sweep_pos = r_sweep_pos + AW'(1);
                end
            end
            fmfw_pkg::ST_RUN: begin
                we = s2_write;
                if (pop && (q_cmd.kind == fmfw_pkg::CMD_FILL)) begin
                    n_state     = fmfw_pkg::ST_SWEEP;
                    n_sweep_pos = '0;
                    n_sweep_val = q_cmd.data;
                end
            end
            default: n_state = fmfw_pkg::ST_RUN;
        endcase

        if (adv) begin
            n_s2_valid  = enter;
            if (enter) begin
                n_s2 = q_cmd;
            end
            n_fwd_valid = s2_write && enter;
            n_fwd_addr  = r_s2.addr;
            n_fwd_data  = merged;
        end

        if (s2_read && adv) begin
            n_out_valid = 1'b1;
            n_out_addr  = r_s2.raddr;
            n_out_val   = r_s2.oob ? 8'h00 : cur;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmfw_pkg::ST_SWEEP;
            r_sweep_pos <= '0;
            r_sweep_val <= fmfw_pkg::STORE_RESET_VALUE;
            r_clearing  <= 1'b1;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_pos <= n_sweep_pos;
            r_sweep_val <= n_sweep_val;
            r_clearing  <= n_clearing;
            r_s2_valid  <= n_s2_valid;
            r_fwd_valid <= n_fwd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2       <= n_s2;
        r_fwd_addr <= n_fwd_addr;
        r_fwd_data <= n_fwd_data;
        r_out_addr <= n_out_addr;
        r_out_val  <= n_out_val;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem_store[rd_addr];
        end
    end

    assign o_pop            = pop;
    assign o_status.clearing = r_clearing;
    assign o_out_valid      = r_out_valid;
    assign o_byte_address   = r_out_addr;
    assign o_byte_value     = r_out_val;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for packed_mono_framebuffer_writer: directed layout, fill and read checks,
// then random pixel traffic in several idle and stall phases, scored against a frame model.
// Depends on fmfw_pkg and the RTL top level; reads no files.
module testbench;

    localparam int PANEL_LONG       = fmfw_pkg::PANEL_LONG_DEF;
    localparam int PANEL_SHORT      = fmfw_pkg::PANEL_SHORT_DEF;
    localparam int STORE_LEN        = PANEL_LONG * PANEL_SHORT / 8;
    // Slowest correct run is roughly the reset sweep plus ~10 fills plus the
    // request traffic; this limit is several times that.
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 475;
    // Slack to leave after the last read returns, before touching registers.
    localparam int SETTLE_CYCLES    = 16;

    typedef struct {
        logic [13:0] addr;
        logic [7:0]  value;
    } t_read_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [8:0]  i_pixel_x;
    logic [8:0]  i_pixel_y;
    logic [7:0]  i_data_value;
    logic [13:0] i_read_address;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [13:0] o_byte_address;
    logic [7:0]  o_byte_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Frame model: the store, the two registers, and the reads still owed.
    logic [7:0]   frame_model [STORE_LEN];
    logic         model_landscape;
    logic         model_black_is_zero;
    t_read_result pending_reads [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Last pixel that landed on the panel; bursts around it hit its byte and its neighbours.
    logic [8:0] last_x = '0;
    logic [8:0] last_y = '0;
    int         last_index = 0;

    packed_mono_framebuffer_writer #(
        .PANEL_LONG (PANEL_LONG),
        .PANEL_SHORT(PANEL_SHORT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_data_value  (i_data_value),
        .i_read_address(i_read_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_address(o_byte_address),
        .o_byte_value  (o_byte_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side backpressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Read results must come back in request order, field for field.
    always @(posedge i_clk) begin : score_reads
        t_read_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected read result addr 0x%0h value 0x%02h",
                         $time, o_byte_address, o_byte_value);
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                if (o_byte_address !== want.addr) begin
                    $display("%0t: byte_address expected 0x%0h actual 0x%0h",
                             $time, want.addr, o_byte_address);
                    error_count++;
                end
                if (o_byte_value !== want.value) begin
                    $display("%0t: byte_value at 0x%0h expected 0x%02h actual 0x%02h",
                             $time, want.addr, want.value, o_byte_value);
                    error_count++;
                end
            end
        end
    end

    // Byte index and bit number of a pixel under the current layout.
    // Returns 0 when the pixel is off the panel or past the store.
    function automatic logic locate_pixel(input logic [8:0] x, input logic [8:0] y,
                                          output int idx, output int bit_pos);
        int xi;
        int yi;
        int iy;
        xi = x;
        yi = y;
        idx = 0;
        bit_pos = 0;
        if (model_landscape) begin
            if (xi >= PANEL_LONG || yi >= PANEL_SHORT) return 1'b0;
            // 2x4 tile, rows counted from the bottom
            iy = PANEL_SHORT - 1 - yi;
            idx = (xi >> 1) * (PANEL_SHORT >> 2) + (iy >> 2);
            bit_pos = 7 - (((iy & 3) << 1) | (xi & 1));
        end else begin
            if (xi >= PANEL_SHORT || yi >= PANEL_LONG) return 1'b0;
            // 4x2 tile
            idx = (yi >> 1) * (PANEL_SHORT >> 2) + (xi >> 2);
            bit_pos = 7 - (((xi & 3) << 1) | (yi & 1));
        end
        return (idx < STORE_LEN);
    endfunction

    // Advance the frame model by one accepted request.
    function automatic void apply_request(input fmfw_pkg::t_op op, input logic [8:0] x,
                                          input logic [8:0] y, input logic [7:0] d,
                                          input logic [13:0] a);
        int           idx;
        int           bit_pos;
        logic         white;
        t_read_result r;
        case (op)
            fmfw_pkg::OP_SET, fmfw_pkg::OP_BLIT: begin
                if (op == fmfw_pkg::OP_SET) white = (d != 8'h00);
                else                        white = model_black_is_zero ? d[0] : ~d[0];
                if (locate_pixel(x, y, idx, bit_pos)) frame_model[idx][bit_pos] = white;
            end
            fmfw_pkg::OP_FILL: begin
                for (int i = 0; i < STORE_LEN; i++) frame_model[i] = d;
            end
            default: begin
                r.addr  = a;
                r.value = (int'(a) < STORE_LEN) ? frame_model[a] : 8'h00;
                pending_reads.push_back(r);
            end
        endcase
    endfunction

    // Present one request after a random gap and hold it until taken.
    // Returns on the accepting edge with valid still high.
    task automatic send_request(input fmfw_pkg::t_op op, input logic [8:0] x,
                                input logic [8:0] y, input logic [7:0] d,
                                input logic [13:0] a);
        int gap;
        gap = 0;
        @(negedge i_clk);
        while (gap < 24 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            gap++;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_operation    = op;
        i_pixel_x      = x;
        i_pixel_y      = y;
        i_data_value   = d;
        i_read_address = a;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(op, x, y, d, a);
    endtask

    // Unused fields carry random junk so every input bit moves.
    task automatic send_pixel(input fmfw_pkg::t_op op, input logic [8:0] x,
                              input logic [8:0] y, input logic [7:0] d);
        int idx;
        int bit_pos;
        if (locate_pixel(x, y, idx, bit_pos)) begin
            last_x     = x;
            last_y     = y;
            last_index = idx;
        end
        send_request(op, x, y, d, 14'($urandom_range(16383)));
    endtask

    task automatic send_read(input logic [13:0] a);
        send_request(fmfw_pkg::OP_READ, 9'($urandom_range(511)), 9'($urandom_range(511)),
                     8'($urandom_range(255)), a);
    endtask

    task automatic send_fill(input logic [7:0] d);
        send_request(fmfw_pkg::OP_FILL, 9'($urandom_range(511)), 9'($urandom_range(511)),
                     d, 14'($urandom_range(16383)));
    endtask

    task automatic hold_requests();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_for_reads();
        hold_requests();
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    // A read queues behind any fill or write still in flight, so once it
    // returns the block is idle and registers may be touched.
    task automatic settle_block();
        send_read(14'($urandom_range(STORE_LEN - 1)));
        wait_for_reads();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_register(input logic idx, input logic want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'b0, want}) begin
            $display("%0t: register %0d expected 0x%0h actual 0x%0h",
                     $time, idx, want, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_register(input logic idx, input logic value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {31'b0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == fmfw_pkg::REG_LANDSCAPE) model_landscape = value;
        else                                model_black_is_zero = value;
        check_register(idx, value);
    endtask

    // Store must come up all ones; reads past the end give zero.
    task automatic test_power_on();
        check_register(fmfw_pkg::REG_LANDSCAPE, 1'b1);
        check_register(fmfw_pkg::REG_POLARITY, 1'b1);
        send_read(14'd0);
        send_read(14'(STORE_LEN - 1));
        send_read(14'(STORE_LEN));
        send_read(14'h3FFF);
    endtask

    task automatic test_portrait_layout();
        settle_block();
        write_register(fmfw_pkg::REG_LANDSCAPE, 1'b0);
        write_register(fmfw_pkg::REG_POLARITY, 1'b1);
        send_pixel(fmfw_pkg::OP_SET, 9'd0, 9'd0, 8'h00);        // top-left, byte 0 bit 7
        send_pixel(fmfw_pkg::OP_SET, 9'd299, 9'd399, 8'h00);    // bottom-right, last byte
        send_pixel(fmfw_pkg::OP_SET, 9'd300, 9'd0, 8'h00);      // one past the width
        send_pixel(fmfw_pkg::OP_SET, 9'd0, 9'd400, 8'h00);      // one past the height
        send_pixel(fmfw_pkg::OP_BLIT, 9'd511, 9'd511, 8'h00);   // far off panel: dropped
        send_pixel(fmfw_pkg::OP_BLIT, 9'd1, 9'd1, 8'hFE);       // source bit 0 -> black
        send_read(14'd0);
        send_read(14'(STORE_LEN - 1));
    endtask

    task automatic test_landscape_layout();
        settle_block();
        write_register(fmfw_pkg::REG_LANDSCAPE, 1'b1);
        write_register(fmfw_pkg::REG_POLARITY, 1'b0);
        send_pixel(fmfw_pkg::OP_SET, 9'd0, 9'd0, 8'h00);        // rows inverted: byte 74
        send_pixel(fmfw_pkg::OP_SET, 9'd399, 9'd299, 8'h00);    // byte 14925
        send_pixel(fmfw_pkg::OP_SET, 9'd400, 9'd0, 8'h00);      // off panel
        send_pixel(fmfw_pkg::OP_SET, 9'd0, 9'd300, 8'h00);      // off panel
        send_pixel(fmfw_pkg::OP_BLIT, 9'd1, 9'd0, 8'h01);       // inverted polarity: black
        send_pixel(fmfw_pkg::OP_BLIT, 9'd0, 9'd0, 8'hFE);       // and back to white
        send_read(14'd74);
        send_read(14'd14925);
    endtask

    task automatic test_fill_and_read();
        send_fill(8'h00);
        send_read(14'd0);
        send_read(14'(STORE_LEN - 1));
        send_pixel(fmfw_pkg::OP_SET, 9'd5, 9'd7, 8'h80);        // right behind a fill
        send_read(14'(last_index));
        send_fill(8'hA5);
        send_read(14'd7);
    endtask

    // Mostly bursts of pixels around the last on-panel pixel and reads of its byte,
    // with random pixels, wild coordinates, stray reads and rare fills mixed in.
    task automatic test_random_traffic(input int idle_pct, input int stall, input logic land,
                                       input logic polarity, input int count);
        int            roll;
        int            w;
        int            h;
        fmfw_pkg::t_op op;
        logic [7:0]    d;
        settle_block();
        write_register(fmfw_pkg::REG_LANDSCAPE, land);
        write_register(fmfw_pkg::REG_POLARITY, polarity);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        w = model_landscape ? PANEL_LONG : PANEL_SHORT;
        h = model_landscape ? PANEL_SHORT : PANEL_LONG;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(99) == 0) wait_for_reads();
            roll = $urandom_range(999);
            op   = $urandom_range(1) ? fmfw_pkg::OP_BLIT : fmfw_pkg::OP_SET;
            d    = $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00;
            if (roll < 3) begin
                send_fill(8'($urandom_range(255)));
            end else if (roll < 80) begin
                send_read(14'($urandom_range(16383)));
            end else if (roll < 300) begin
                send_read(14'(last_index));
            end else if (roll < 330) begin
                send_pixel(op, 9'($urandom_range(511)), 9'($urandom_range(511)), d);
            end else if (roll < 650) begin
                // panel sizes are multiples of four, so this stays on the panel
                // unless the layout changed since the last on-panel pixel
                send_pixel(op, last_x ^ 9'($urandom_range(3)), last_y ^ 9'($urandom_range(3)),
                           d);
            end else begin
                send_pixel(op, 9'($urandom_range(w - 1)), 9'($urandom_range(h - 1)), d);
            end
        end
        hold_requests();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = fmfw_pkg::OP_SET;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_data_value   = '0;
        i_read_address = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        for (int i = 0; i < STORE_LEN; i++) frame_model[i] = fmfw_pkg::STORE_RESET_VALUE;
        model_landscape     = 1'b1;
        model_black_is_zero = 1'b1;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_on();
        test_portrait_layout();
        test_landscape_layout();
        test_fill_and_read();
        test_random_traffic(0, 0, 1'b1, 1'b1, RANDOM_PER_PHASE);
        test_random_traffic(45, 0, 1'b0, 1'b0, RANDOM_PER_PHASE);
        test_random_traffic(0, 45, 1'b0, 1'b1, RANDOM_PER_PHASE);
        test_random_traffic(31, 31, 1'b1, 1'b0, RANDOM_PER_PHASE);

        wait_for_reads();
        repeat (32) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
